[hw/rtl/slle_pkg.sv]
// ----------------------------------------------------------------------------
// slle_pkg
// Shared types and constants of the static linked list engine: field widths,
// status and action codes, and the command and status records that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package slle_pkg;

	localparam int SLLE_SLOTS_DEF = 1024;
	localparam int POS_W          = 10;
	localparam int VAL_W          = 32;
	localparam int CNT_OUT_W      = 10;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Read address source of the link memory.
	typedef enum logic [1:0] {
		RA_ZERO,
		RA_CUR,
		RA_RD
	} raddr_sel_t;

	// Write address source of the link memory.
	typedef enum logic [1:0] {
		WA_ZERO,
		WA_FRESH,
		WA_CUR,
		WA_CLEAR
	} waddr_sel_t;

	// Write data source of the link memory.
	typedef enum logic [1:0] {
		WD_RD,
		WD_FRESH,
		WD_CLEAR
	} wdata_sel_t;

	typedef struct packed {
		raddr_sel_t raddr_sel;
		logic       wen;
		waddr_sel_t waddr_sel;
		wdata_sel_t wdata_sel;
		logic       clr_step;
		logic       load_item;
		logic       fresh_load;
		logic       walk_step;
		logic       val_we;
		logic       count_inc;
		logic       count_dec;
		logic       out_load;
		status_t    out_status;
	} slle_cmd_t;

	typedef struct packed {
		logic range_bad;
		logic fresh_zero;
		logic left_zero;
		logic left_one;
		logic clr_last;
	} slle_stat_t;

endpackage

[hw/rtl/slle_datapath.sv]
// ----------------------------------------------------------------------------
// slle_datapath
// Link and value memories, walk pointer, step counter, element count and the
// result register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module slle_datapath import slle_pkg::*; #(
	parameter int SLOTS = SLLE_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slle_cmd_t            cmd,
	output slle_stat_t           stat,
	input  logic                 action,
	input  logic [POS_W-1:0]     position,
	input  logic signed [VAL_W-1:0] value,
	output logic [1:0]           status,
	output logic [CNT_OUT_W-1:0] element_count
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = SW;
	localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam logic [SW-1:0] HEAD      = SW'(SLOTS - 1);
	localparam logic [SW-1:0] CLR_LAST  = SW'(SLOTS - 1);
	localparam logic [SW-1:0] CLR_CHAIN = SW'(SLOTS - 3);

	logic [SW-1:0]          link_mem [SLOTS];
	logic [VAL_W-1:0]       value_mem [SLOTS];

	logic [SW-1:0]          rd_q;
	logic [SW-1:0]          rd_ok;
	logic [SW-1:0]          cur_q;
	logic [SW-1:0]          fresh_q;
	logic [POS_W-1:0]       left_q;
	logic [VAL_W-1:0]       val_q;
	logic [CW-1:0]          count_q;
	logic [SW-1:0]          clr_q;
	status_t                status_q;
	logic [CNT_OUT_W-1:0]   element_count_q;

	logic [SW-1:0]          raddr;
	logic [SW-1:0]          waddr;
	logic [SW-1:0]          wdata;
	logic [EW-1:0]          pos_ext;
	logic [EW-1:0]          cnt_ext;
	logic [EW-1:0]          cnt_out_ext;

	// A link that names no slot counts as slot 0.
	assign rd_ok = ({1'b0, rd_q} < (SW + 1)'(SLOTS)) ? rd_q : '0;

	always_comb begin
		case (cmd.raddr_sel)
			RA_ZERO: raddr = '0;
			RA_CUR:  raddr = cur_q;
			RA_RD:   raddr = rd_ok;
			default: raddr = '0;
		endcase
		case (cmd.waddr_sel)
			WA_ZERO:  waddr = '0;
			WA_FRESH: waddr = fresh_q;
			WA_CUR:   waddr = cur_q;
			WA_CLEAR: waddr = clr_q;
			default:  waddr = '0;
		endcase
		case (cmd.wdata_sel)
			WD_RD:    wdata = rd_ok;
			WD_FRESH: wdata = fresh_q;
			WD_CLEAR: wdata = (clr_q <= CLR_CHAIN) ? SW'(clr_q + 1'b1) : '0;
			default:  wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wen) begin
			link_mem[waddr] <= wdata;
		end
		rd_q <= link_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.val_we) begin
			value_mem[fresh_q] <= val_q;
		end
	end

	assign pos_ext = EW'(position);
	assign cnt_ext = EW'(count_q);

	always_comb begin
		if (action == ACT_INSERT) begin
			stat.range_bad = (pos_ext == '0) || (pos_ext > EW'(cnt_ext + 1'b1));
		end else begin
			stat.range_bad = (pos_ext == '0) || (pos_ext > cnt_ext);
		end
		stat.fresh_zero = (rd_ok == '0);
		stat.left_zero  = (left_q == '0);
		stat.left_one   = (left_q == POS_W'(1));
		stat.clr_last   = (clr_q == CLR_LAST);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			val_q  <= value;
			left_q <= position - 1'b1;
			cur_q  <= HEAD;
		end else if (cmd.walk_step) begin
			left_q <= left_q - 1'b1;
			cur_q  <= rd_ok;
		end
		if (cmd.fresh_load) begin
			fresh_q <= rd_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.count_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.count_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign cnt_out_ext = EW'(count_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q        <= cmd.out_status;
			element_count_q <= cnt_out_ext[CNT_OUT_W-1:0];
		end
	end

	assign status        = status_q;
	assign element_count = element_count_q;

endmodule

[hw/rtl/slle_ctrl.sv]
// ----------------------------------------------------------------------------
// slle_ctrl
// Sequencer of the engine: clearing pass, insert and delete sequences, the
// shared link walk, and the output valid flag.
// ----------------------------------------------------------------------------
module slle_ctrl import slle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	output logic       out_valid,
	input  logic       out_ready,
	input  slle_stat_t stat,
	output slle_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_I_FRESH,
		S_I_NEXT,
		S_W_START,
		S_W_STEP,
		S_I_LINK,
		S_I_PREV,
		S_D_GONE,
		S_D_NG,
		S_D_F0,
		S_D_HEAD,
		S_FINISH
	} state_t;

	state_t  state_q, state_d;
	logic    del_q, del_d;
	status_t stat_q, stat_d;
	logic    out_valid_q;
	logic    out_free;
	state_t  after_walk;

	assign out_free   = !out_valid_q || out_ready;
	assign after_walk = del_q ? S_D_GONE : S_I_LINK;

	always_comb begin
		cmd            = '0;
		cmd.raddr_sel  = RA_ZERO;
		cmd.waddr_sel  = WA_ZERO;
		cmd.wdata_sel  = WD_RD;
		cmd.out_status = stat_q;
		state_d        = state_q;
		del_d          = del_q;
		stat_d         = stat_q;
		in_ready       = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.wen       = 1'b1;
				cmd.waddr_sel = WA_CLEAR;
				cmd.wdata_sel = WD_CLEAR;
				cmd.clr_step  = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					del_d         = (action == ACT_DELETE);
					if (stat.range_bad) begin
						stat_d  = ST_RANGE;
						state_d = S_FINISH;
					end else if (action == ACT_INSERT) begin
						stat_d        = ST_OK;
						cmd.raddr_sel = RA_ZERO;
						state_d       = S_I_FRESH;
					end else begin
						stat_d  = ST_OK;
						state_d = S_W_START;
					end
				end
			end
			S_I_FRESH: begin
				if (stat.fresh_zero) begin
					stat_d  = ST_FULL;
					state_d = S_FINISH;
				end else begin
					cmd.fresh_load = 1'b1;
					cmd.raddr_sel  = RA_RD;
					state_d        = S_I_NEXT;
				end
			end
			S_I_NEXT: begin
				cmd.wen       = 1'b1;
				cmd.waddr_sel = WA_ZERO;
				cmd.wdata_sel = WD_RD;
				cmd.val_we    = 1'b1;
				state_d       = S_W_START;
			end
			S_W_START: begin
				cmd.raddr_sel = RA_CUR;
				state_d       = stat.left_zero ? after_walk : S_W_STEP;
			end
			S_W_STEP: begin
				cmd.walk_step = 1'b1;
				cmd.raddr_sel = RA_RD;
				if (stat.left_one) begin
					state_d = after_walk;
				end
			end
			S_I_LINK: begin
				cmd.wen       = 1'b1;
				cmd.waddr_sel = WA_FRESH;
				cmd.wdata_sel = WD_RD;
				state_d       = S_I_PREV;
			end
			S_I_PREV: begin
				cmd.wen       = 1'b1;
				cmd.waddr_sel = WA_CUR;
				cmd.wdata_sel = WD_FRESH;
				cmd.count_inc = 1'b1;
				state_d       = S_FINISH;
			end
			S_D_GONE: begin
				cmd.fresh_load = 1'b1;
				cmd.raddr_sel  = RA_RD;
				state_d        = S_D_NG;
			end
			S_D_NG: begin
				cmd.wen       = 1'b1;
				cmd.waddr_sel = WA_CUR;
				cmd.wdata_sel = WD_RD;
				cmd.raddr_sel = RA_ZERO;
				state_d       = S_D_F0;
			end
			S_D_F0: begin
				cmd.wen       = 1'b1;
				cmd.waddr_sel = WA_FRESH;
				cmd.wdata_sel = WD_RD;
				state_d       = S_D_HEAD;
			end
			S_D_HEAD: begin
				cmd.wen       = 1'b1;
				cmd.waddr_sel = WA_ZERO;
				cmd.wdata_sel = WD_FRESH;
				cmd.count_dec = 1'b1;
				state_d       = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			del_q       <= 1'b0;
			stat_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			del_q   <= del_d;
			stat_q  <= stat_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/static_linked_list_engine.sv]
// ----------------------------------------------------------------------------
// static_linked_list_engine
// Singly linked list held in a fixed array of slots, with a free chain.
// ----------------------------------------------------------------------------
//
//   channel  handshake             fields
//   -------  --------------------  ------------------------------------------
//   input    in_valid / in_ready   action (1), position (10), value (32, s)
//   output   out_valid / out_ready status (2), element_count (10)
//
// After reset the engine runs a clearing pass that writes the initial free
// chain into the link memory; in_ready stays low meanwhile.
// Once its sequence ends, a result is loaded into the output register and
// out_valid rises, as soon as that register is free. A position out of range
// goes straight to the result and a full list ends after the free chain head
// is read; a valid insert or delete first walks the list by its position over
// the single read port of the link memory, which follows one link per cycle.
// One item is worked at a time. A new beat is taken while the previous result
// still waits in the output register; the finished result is held until that
// register frees, so stalls on the output side never lose a result.
//
// Slot 0 heads the free chain and slot SLOTS-1 heads the list. The controller
// sequences memory reads and writes so that no read whose data is used ever
// targets a slot being written in the same cycle. The value memory is written
// on every successful insert and no result field ever reads it back.
// ----------------------------------------------------------------------------
module static_linked_list_engine import slle_pkg::*; #(
	parameter int SLOTS = SLLE_SLOTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    action,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              status,
	output logic [CNT_OUT_W-1:0]    element_count
);

	slle_cmd_t  cmd;
	slle_stat_t stat;

	// The controller decides the whole sequence; the datapath only obeys.
	slle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath owns the memories, the walk pointer and the count.
	slle_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (action),
		.position      (position),
		.value         (value),
		.status        (status),
		.element_count (element_count)
	);

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the static linked list engine. A scripted opening
// covers empty-list errors, value extremes and head, tail and middle splices.
// Random mixed traffic follows, then a burst of inserts against a stalled
// result side, then deep random traffic over the whole list. Every result
// beat is checked against a behavioral mirror of the slot links and the
// element count. Both channels idle at random, and the result side holds
// off for a long stretch once so that the engine stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import slle_pkg::*;

	localparam int NSLOT    = SLLE_SLOTS_DEF;
	localparam int MAX_ELEM = NSLOT - 2;

	typedef struct packed {
		status_t              st;
		logic [CNT_OUT_W-1:0] cnt;
	} list_reply_t;

	// One scripted beat. Where typed is set, st and cnt are the reply
	// written out by hand; otherwise the mirror supplies the reply.
	typedef struct packed {
		logic                 act;
		logic [POS_W-1:0]     pos;
		logic [VAL_W-1:0]     val;
		logic                 typed;
		status_t              st;
		logic [CNT_OUT_W-1:0] cnt;
	} list_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 action = ACT_INSERT;
	logic [POS_W-1:0]     position = '0;
	logic [VAL_W-1:0]     value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           status;
	logic [CNT_OUT_W-1:0] element_count;

	// Mirror of the engine: the link of every slot and the element count.
	int link_mirror [NSLOT];
	int elem_cnt;

	list_reply_t reply_q [$];
	list_row_t   opening_rows [$];

	int fault_cnt   = 0;
	int reply_idx   = 0;
	int tx_calm     = 0;
	int rx_calm     = 0;
	int rx_idle     = 0;
	int hold_cycles = 0;
	bit tx_eager    = 1'b0;

	static_linked_list_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.position     (position),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.element_count(element_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Most gaps are zero or short, a few are long, and now and then a calm
	// run of back-to-back cycles with no gap at all.
	function automatic int pick_idle(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic void mirror_reset();
		for (int s = 0; s < NSLOT - 2; s++) link_mirror[s] = s + 1;
		link_mirror[NSLOT-2] = 0;
		link_mirror[NSLOT-1] = 0;
		elem_cnt = 0;
	endfunction

	// Follow the given number of links starting at the list head slot.
	function automatic int walk_links(int steps);
		int cur;
		cur = NSLOT - 1;
		for (int n = 0; n < steps; n++) cur = link_mirror[cur];
		return cur;
	endfunction

	// Apply one command to the mirror and return the reply it produces.
	// The range check comes first, so a full list with a bad position
	// still reports a range error.
	function automatic list_reply_t list_apply(logic act, int pos);
		list_reply_t r;
		int fresh;
		int prev;
		int gone;
		r.st = ST_OK;
		if (act == ACT_INSERT) begin
			if (pos < 1 || pos > elem_cnt + 1) begin
				r.st = ST_RANGE;
			end else begin
				fresh = link_mirror[0];
				if (fresh == 0) begin
					r.st = ST_FULL;
				end else begin
					link_mirror[0] = link_mirror[fresh];
					prev = walk_links(pos - 1);
					link_mirror[fresh] = link_mirror[prev];
					link_mirror[prev] = fresh;
					elem_cnt++;
				end
			end
		end else begin
			if (pos < 1 || pos > elem_cnt) begin
				r.st = ST_RANGE;
			end else begin
				prev = walk_links(pos - 1);
				gone = link_mirror[prev];
				link_mirror[prev] = link_mirror[gone];
				link_mirror[gone] = link_mirror[0];
				link_mirror[0] = gone;
				elem_cnt--;
			end
		end
		r.cnt = CNT_OUT_W'(elem_cnt);
		return r;
	endfunction

	// Offer one command beat. Called and returning at a falling edge, so
	// valid is either held high into the next beat or lowered for a gap,
	// never both in one step.
	task automatic send_beat(input logic act, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val, input logic typed,
			input status_t st, input logic [CNT_OUT_W-1:0] cnt);
		int gap;
		list_reply_t predicted;
		gap = tx_eager ? 0 : pick_idle(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		position <= pos;
		value    <= val;
		do @(posedge clk); while (!in_ready);
		predicted = list_apply(act, int'(pos));
		if (typed) reply_q.push_back('{st, cnt});
		else reply_q.push_back(predicted);
		@(negedge clk);
	endtask

	task automatic run_rows(input list_row_t rows [$]);
		foreach (rows[i])
			send_beat(rows[i].act, rows[i].pos, rows[i].val, rows[i].typed,
				rows[i].st, rows[i].cnt);
	endtask

	// Mostly well-formed commands with random content, the rest mostly malformed
	// positions. With deep set, positions spread over the whole list, which
	// makes the engine walk long chains.
	task automatic random_op(input int ins_pct, input bit deep);
		logic act;
		int pos;
		int lim;
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			act = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 2))
				0: pos = 0;
				1: pos = (act == ACT_INSERT) ? elem_cnt + 2 : elem_cnt + 1;
				default: pos = $urandom_range(0, 1023);
			endcase
			if (pos > 1023) pos = 1023;
		end else begin
			if (elem_cnt == 0) act = ACT_INSERT;
			else if (elem_cnt >= MAX_ELEM) act = ACT_DELETE;
			else act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_DELETE;
			lim = (act == ACT_INSERT) ? elem_cnt + 1 : elem_cnt;
			r = $urandom_range(0, 9);
			if (deep || r == 0) pos = $urandom_range(1, lim);
			else if (r < 3) pos = lim;
			else pos = $urandom_range(1, (lim < 8) ? lim : 8);
		end
		send_beat(act, POS_W'(pos), VAL_W'($urandom), 1'b0, ST_OK, '0);
	endtask

	// Result side: random ready gaps, plus one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else if (rx_idle > 0) begin
				out_ready <= 1'b0;
				rx_idle--;
			end else begin
				out_ready <= 1'b1;
				rx_idle = pick_idle(rx_calm);
			end
		end
	end

	// Every accepted result beat is matched against the oldest reply owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (reply_q.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= 10)
					$display("result %0d with nothing owed: status %0d count %0d",
						reply_idx, status, element_count);
			end else begin
				if (status !== reply_q[0].st || element_count !== reply_q[0].cnt) begin
					fault_cnt++;
					if (fault_cnt <= 10)
						$display("result %0d: expected status %0d count %0d, got status %0d count %0d",
							reply_idx, reply_q[0].st, reply_q[0].cnt, status, element_count);
				end
				void'(reply_q.pop_front());
			end
			reply_idx++;
		end
	end

	initial begin
		int n;
		int pos;

		// Empty list errors, value extremes, head and tail splices, then a
		// few middle splices and deletes that reuse freed slots.
		opening_rows.push_back('{ACT_DELETE, 10'd1,    32'h0000_0000, 1'b1, ST_RANGE, 10'd0});
		opening_rows.push_back('{ACT_INSERT, 10'd0,    32'h0000_0000, 1'b1, ST_RANGE, 10'd0});
		opening_rows.push_back('{ACT_INSERT, 10'd2,    32'h1234_5678, 1'b1, ST_RANGE, 10'd0});
		opening_rows.push_back('{ACT_INSERT, 10'd1023, 32'h0000_0000, 1'b1, ST_RANGE, 10'd0});
		opening_rows.push_back('{ACT_INSERT, 10'd1,    32'h7FFF_FFFF, 1'b1, ST_OK,    10'd1});
		opening_rows.push_back('{ACT_INSERT, 10'd2,    32'h8000_0000, 1'b1, ST_OK,    10'd2});
		opening_rows.push_back('{ACT_INSERT, 10'd1,    32'hFFFF_FFFF, 1'b1, ST_OK,    10'd3});
		opening_rows.push_back('{ACT_INSERT, 10'd4,    32'h0000_0000, 1'b1, ST_OK,    10'd4});
		opening_rows.push_back('{ACT_INSERT, 10'd6,    32'h0000_0001, 1'b1, ST_RANGE, 10'd4});
		opening_rows.push_back('{ACT_DELETE, 10'd5,    32'h0000_0000, 1'b1, ST_RANGE, 10'd4});
		opening_rows.push_back('{ACT_DELETE, 10'd0,    32'h0000_0000, 1'b1, ST_RANGE, 10'd4});
		opening_rows.push_back('{ACT_DELETE, 10'd4,    32'h0000_0000, 1'b1, ST_OK,    10'd3});
		opening_rows.push_back('{ACT_DELETE, 10'd1,    32'h0000_0000, 1'b1, ST_OK,    10'd2});
		opening_rows.push_back('{ACT_DELETE, 10'd1023, 32'hFFFF_FFFF, 1'b1, ST_RANGE, 10'd2});
		opening_rows.push_back('{ACT_INSERT, 10'd2,    32'h5555_5555, 1'b0, ST_OK,    10'd0});
		opening_rows.push_back('{ACT_INSERT, 10'd3,    32'hAAAA_AAAA, 1'b0, ST_OK,    10'd0});
		opening_rows.push_back('{ACT_DELETE, 10'd2,    32'h0000_0000, 1'b0, ST_OK,    10'd0});
		opening_rows.push_back('{ACT_INSERT, 10'd1,    32'h0000_0001, 1'b0, ST_OK,    10'd0});
		opening_rows.push_back('{ACT_DELETE, 10'd1,    32'h0000_0000, 1'b0, ST_OK,    10'd0});
		opening_rows.push_back('{ACT_DELETE, 10'd1,    32'h0000_0000, 1'b0, ST_OK,    10'd0});

		mirror_reset();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		run_rows(opening_rows);

		// Mixed traffic on a short list, leaning toward inserts.
		for (n = 0; n < 200; n++) random_op(60, 1'b0);

		// A burst of inserts sent back to back while the result side holds
		// off, so the engine backs up and stalls its input.
		tx_eager = 1'b1;
		hold_cycles = 400;
		for (n = 0; n < 80; n++) begin
			case ($urandom_range(0, 19))
				0: pos = elem_cnt + 1;
				1, 2: pos = $urandom_range(1, (elem_cnt < 15) ? elem_cnt + 1 : 16);
				default: pos = $urandom_range(1, (elem_cnt < 3) ? elem_cnt + 1 : 4);
			endcase
			send_beat(ACT_INSERT, POS_W'(pos), VAL_W'($urandom), 1'b0, ST_OK, '0);
		end
		tx_eager = 1'b0;

		// Long walks over the whole list.
		for (n = 0; n < 150; n++) random_op(50, 1'b1);

		in_valid <= 1'b0;

		while (reply_q.size() != 0) @(posedge clk);
		repeat (1040) @(posedge clk);

		if (fault_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
